FILE: src/half_step_stepper_sequencer_top_defines.svh
// Assertion macros for the stepper sequencer.
`ifndef HALF_STEP_STEPPER_SEQUENCER_TOP_DEFINES_SVH
`define HALF_STEP_STEPPER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper sequencer check failed");

// Next-cycle implication, disabled while reset is high.
`define HSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper sequencer check failed");

`endif

FILE: src/hss_pkg.sv
package hss_pkg;

   typedef enum logic [2:0] {
      REQ_TICK  = 3'd0,
      REQ_START = 3'd1,
      REQ_STOP  = 3'd2,
      REQ_REL   = 3'd3,
      REQ_ABS   = 3'd4
   } hss_req_type;

   typedef enum logic [1:0] {
      CSR_SLOW   = 2'd0,
      CSR_NORMAL = 2'd1,
      CSR_FAST   = 2'd2
   } hss_csr_type;

   localparam logic [1:0] SPEED_SLOW   = 2'd0;
   localparam logic [1:0] SPEED_NORMAL = 2'd1;
   localparam logic [1:0] SPEED_FAST   = 2'd2;

   localparam logic [7:0] SLOW_RESET   = 8'd8;
   localparam logic [7:0] NORMAL_RESET = 8'd4;
   localparam logic [7:0] FAST_RESET   = 8'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic               direction;
      logic [1:0]         speed;
      logic [31:0]        step_count;
      logic signed [31:0] target_position;
   } hss_request_type;

   typedef struct packed {
      logic [7:0] slow;
      logic [7:0] normal;
      logic [7:0] fast;
   } hss_intervals_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic signed [31:0] position;
      logic               moving;
      logic               running;
      logic               step_taken;
      logic               rejected;
   } hss_result_type;

   // Half-step coil pattern for each phase, bit0 is coil one.
   function automatic logic [3:0] coil_of(input logic [2:0] phase);
      logic [3:0] pattern;
      case (phase)
         3'd0:    pattern = 4'h1;
         3'd1:    pattern = 4'h3;
         3'd2:    pattern = 4'h2;
         3'd3:    pattern = 4'h6;
         3'd4:    pattern = 4'h4;
         3'd5:    pattern = 4'hC;
         3'd6:    pattern = 4'h8;
         3'd7:    pattern = 4'h9;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

   function automatic logic [7:0] interval_of(input logic [1:0] speed,
                                              input hss_intervals_type iv);
      logic [7:0] value;
      case (speed)
         SPEED_SLOW: value = iv.slow;
         SPEED_FAST: value = iv.fast;
         default:    value = iv.normal;
      endcase
      return value;
   endfunction

   // Saturating increment of an elapsed tick count.
   function automatic logic [7:0] bump(input logic [7:0] value);
      return (value == 8'hFF) ? 8'hFF : value + 8'd1;
   endfunction

endpackage

FILE: src/hss_core.sv
module hss_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  hss_pkg::hss_request_type   request,
   input  hss_pkg::hss_intervals_type intervals,
   output hss_pkg::hss_result_type    result
);
   import hss_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] position_ff, position_in;
   logic [3:0]  coils_ff, coils_in;
   logic        cont_running_ff, cont_running_in;
   logic        cont_dir_ff, cont_dir_in;
   logic [1:0]  cont_speed_ff, cont_speed_in;
   logic [7:0]  cont_elapsed_ff, cont_elapsed_in;
   logic [31:0] move_remaining_ff, move_remaining_in;
   logic        move_dir_ff, move_dir_in;
   logic [1:0]  move_speed_ff, move_speed_in;
   logic [7:0]  move_elapsed_ff, move_elapsed_in;
   logic        move_active_ff, move_active_in;

   hss_req_type req_kind;
   logic        do_step;
   logic        step_dir;
   logic        rejected;
   logic [7:0]  move_bump;
   logic [7:0]  cont_bump;
   logic [31:0] target;
   logic        go_up;
   logic [31:0] abs_left;

   assign req_kind  = hss_req_type'(request.req_type);
   assign move_bump = bump(move_elapsed_ff);
   assign cont_bump = bump(cont_elapsed_ff);
   assign target    = request.target_position;
   assign go_up     = $signed(request.target_position) > $signed(position_ff);
   // Steps left after the first one: distance minus one, folded into one add.
   assign abs_left  = go_up ? (target + ~position_ff) : (position_ff + ~target);

   always_comb begin
      phase_in          = phase_ff;
      position_in       = position_ff;
      coils_in          = coils_ff;
      cont_running_in   = cont_running_ff;
      cont_dir_in       = cont_dir_ff;
      cont_speed_in     = cont_speed_ff;
      cont_elapsed_in   = cont_elapsed_ff;
      move_remaining_in = move_remaining_ff;
      move_dir_in       = move_dir_ff;
      move_speed_in     = move_speed_ff;
      move_elapsed_in   = move_elapsed_ff;
      move_active_in    = move_active_ff;
      do_step           = 1'b0;
      step_dir          = 1'b0;
      rejected          = 1'b0;

      case (req_kind)
         REQ_TICK: begin
            if (move_active_ff) begin
               move_elapsed_in = move_bump;
               if (move_bump >= interval_of(move_speed_ff, intervals)) begin
                  move_elapsed_in = 8'd0;
                  if (move_remaining_ff != 32'd0) begin
                     do_step           = 1'b1;
                     step_dir          = move_dir_ff;
                     move_remaining_in = move_remaining_ff - 32'd1;
                  end else begin
                     coils_in       = 4'h0;
                     move_active_in = 1'b0;
                  end
               end
            end else if (cont_running_ff) begin
               cont_elapsed_in = cont_bump;
               if (cont_bump >= interval_of(cont_speed_ff, intervals)) begin
                  cont_elapsed_in = 8'd0;
                  do_step         = 1'b1;
                  step_dir        = cont_dir_ff;
               end
            end
         end
         REQ_START: begin
            if (move_active_ff) begin
               rejected = 1'b1;
            end else begin
               cont_dir_in     = request.direction;
               cont_speed_in   = request.speed;
               cont_running_in = 1'b1;
               cont_elapsed_in = 8'd0;
            end
         end
         REQ_STOP: begin
            if (move_active_ff) begin
               rejected = 1'b1;
            end else begin
               cont_running_in = 1'b0;
               coils_in        = 4'h0;
            end
         end
         REQ_REL: begin
            if (move_active_ff) begin
               rejected = 1'b1;
            end else if (request.step_count == 32'd0) begin
               coils_in = 4'h0;
            end else begin
               do_step           = 1'b1;
               step_dir          = request.direction;
               move_remaining_in = request.step_count - 32'd1;
               move_dir_in       = request.direction;
               move_speed_in     = request.speed;
               move_elapsed_in   = 8'd0;
               move_active_in    = 1'b1;
            end
         end
         REQ_ABS: begin
            if (move_active_ff) begin
               rejected = 1'b1;
            end else if (target != position_ff) begin
               do_step           = 1'b1;
               step_dir          = ~go_up;
               move_remaining_in = abs_left;
               move_dir_in       = ~go_up;
               move_speed_in     = request.speed;
               move_elapsed_in   = 8'd0;
               move_active_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (do_step) begin
         phase_in    = step_dir ? (phase_ff - 3'd1) : (phase_ff + 3'd1);
         position_in = step_dir ? (position_ff - 32'd1) : (position_ff + 32'd1);
         coils_in    = coil_of(phase_in);
      end
   end

   assign result.coils      = coils_in;
   assign result.position   = position_in;
   assign result.moving     = move_active_in;
   assign result.running    = cont_running_in;
   assign result.step_taken = do_step;
   assign result.rejected   = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= 3'd0;
         position_ff       <= 32'd0;
         coils_ff          <= 4'h0;
         cont_running_ff   <= 1'b0;
         cont_dir_ff       <= 1'b0;
         cont_speed_ff     <= SPEED_NORMAL;
         cont_elapsed_ff   <= 8'd0;
         move_remaining_ff <= 32'd0;
         move_dir_ff       <= 1'b0;
         move_speed_ff     <= SPEED_SLOW;
         move_elapsed_ff   <= 8'd0;
         move_active_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         position_ff       <= position_in;
         coils_ff          <= coils_in;
         cont_running_ff   <= cont_running_in;
         cont_dir_ff       <= cont_dir_in;
         cont_speed_ff     <= cont_speed_in;
         cont_elapsed_ff   <= cont_elapsed_in;
         move_remaining_ff <= move_remaining_in;
         move_dir_ff       <= move_dir_in;
         move_speed_ff     <= move_speed_in;
         move_elapsed_ff   <= move_elapsed_in;
         move_active_ff    <= move_active_in;
      end
   end

endmodule

FILE: src/half_step_stepper_sequencer_top.sv
// Half-step sequencer for a four-coil unipolar stepper.
// An accepted request passes the input register, then the result register, before rsp_tvalid rises.
// Throughput: one request per cycle; req_tready drops only while both registers are full
// and rsp_tready is low, following rsp_tready within the same cycle.
// Reset (synchronous, active high): coils off, position 0, no move, not running,
// intervals back to 8, 4 and 2 ticks.
module half_step_stepper_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // direction, speed[1:0], step_count[31:0],
                                   // target_position[31:0], zero fill
   input  logic [2:0]  req_tuser,  // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // coils[3:0], position[31:0], moving, running,
                                   // step_taken, rejected
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import hss_pkg::*;

   `include "half_step_stepper_sequencer_top_defines.svh"

   logic              in_valid_ff, in_valid_in;
   hss_request_type   in_req_ff, in_req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hss_result_type    rsp_ff;
   hss_result_type    core_result;
   hss_intervals_type intervals_ff;
   logic              out_free;
   logic              advance;
   logic              req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   assign in_req_in.req_type        = req_tuser;
   assign in_req_in.direction       = req_tdata[0];
   assign in_req_in.speed           = req_tdata[2:1];
   assign in_req_in.step_count      = req_tdata[34:3];
   assign in_req_in.target_position = req_tdata[66:35];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request until the core can hand its result on.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= in_req_in;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intervals_ff.slow   <= SLOW_RESET;
         intervals_ff.normal <= NORMAL_RESET;
         intervals_ff.fast   <= FAST_RESET;
      end else if (csr_we) begin
         case (hss_csr_type'(csr_index))
            CSR_SLOW:   intervals_ff.slow   <= csr_wdata;
            CSR_NORMAL: intervals_ff.normal <= csr_wdata;
            CSR_FAST:   intervals_ff.fast   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   hss_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .request   (in_req_ff),
      .intervals (intervals_ff),
      .result    (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.rejected, rsp_ff.step_taken, rsp_ff.running,
                        rsp_ff.moving, rsp_ff.position, rsp_ff.coils};

   // A rejected command leaves the move running.
   `HSS_ASSERT_NOW(a_reject_moving, clock, reset, rsp_valid_ff && rsp_ff.rejected, rsp_ff.moving)
   // A step always leaves one or two adjacent coils energised.
   `HSS_ASSERT_NOW(a_step_coils, clock, reset, rsp_valid_ff && rsp_ff.step_taken,
      ($countones(rsp_ff.coils) == 1) || ($countones(rsp_ff.coils) == 2))
   // A full input register is only refilled when it drains in the same cycle.
   `HSS_ASSERT_NOW(a_no_overwrite, clock, reset, req_accept && in_valid_ff, advance)
   // A request that reaches the core shows up as a result next cycle.
   `HSS_ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_valid_ff)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import hss_pkg::*;

   localparam int          CLK_HALF     = 2;
   localparam int          RESET_CYCLES = 11;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          PHASE_ITEMS  = 420;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [2:0]  REQ_TYPE_MAX = 3'd7;
   localparam logic [1:0]  SPEED_ALT    = 2'd3;
   localparam logic        DIR_CW       = 1'b0;
   localparam logic        DIR_CCW      = 1'b1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;  // direction, speed[1:0], step_count[31:0],
                                  // target_position[31:0], zero fill
   logic [2:0]  req_tuser  = REQ_TICK;  // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;  // coils[3:0], position[31:0], moving, running,
                            // step_taken, rejected
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_SLOW;
   logic [7:0]  csr_wdata  = '0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_request  = 1'b0;
   int unsigned hold_count    = 0;

   half_step_stepper_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   class stepper_scoreboard;
      logic [7:0]     slow_ticks, normal_ticks, fast_ticks;
      logic [3:0]     coil_seq [8];
      logic [2:0]     step_phase;
      logic [31:0]    position;
      logic [3:0]     coils;
      bit             cont_on, cont_dir;
      logic [1:0]     cont_speed;
      logic [7:0]     cont_ticks;
      bit             move_on, move_dir;
      logic [31:0]    move_left;
      logic [1:0]     move_speed;
      logic [7:0]     move_ticks;
      hss_result_type expected_q [$];
      int unsigned    mismatches, requests, steps, rejects, moves_done;

      function new();
         coil_seq   = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
         slow_ticks = SLOW_RESET;
         normal_ticks = NORMAL_RESET;
         fast_ticks = FAST_RESET;
         step_phase = '0;
         position   = '0;
         coils      = '0;
         cont_on    = 1'b0;
         cont_dir   = DIR_CW;
         cont_speed = SPEED_NORMAL;
         cont_ticks = '0;
         move_on    = 1'b0;
         move_dir   = DIR_CW;
         move_left  = '0;
         move_speed = SPEED_SLOW;
         move_ticks = '0;
      endfunction

      function void set_interval(hss_csr_type idx, logic [7:0] value);
         case (idx)
            CSR_SLOW:   slow_ticks = value;
            CSR_NORMAL: normal_ticks = value;
            CSR_FAST:   fast_ticks = value;
            default:    ;
         endcase
      endfunction

      function logic [7:0] ticks_for(logic [1:0] spd);
         if (spd == SPEED_SLOW) return slow_ticks;
         if (spd == SPEED_FAST) return fast_ticks;
         return normal_ticks;
      endfunction

      function logic [7:0] count_tick(logic [7:0] v);
         return (v == 8'hFF) ? v : v + 8'd1;
      endfunction

      function void take_step(bit dir);
         if (dir == DIR_CW) begin
            step_phase = step_phase + 3'd1;
            position   = position + 32'd1;
         end else begin
            step_phase = step_phase - 3'd1;
            position   = position - 32'd1;
         end
         coils = coil_seq[step_phase];
      endfunction

      function void start_move(bit dir, logic [31:0] count, logic [1:0] spd);
         take_step(dir);
         move_left  = count - 32'd1;
         move_dir   = dir;
         move_speed = spd;
         move_ticks = '0;
         move_on    = 1'b1;
      endfunction

      function void note_request(hss_request_type r);
         logic [31:0]    start_pos;
         logic [31:0]    target;
         bit             refused;
         hss_result_type res;
         start_pos = position;
         target    = r.target_position;
         refused   = 1'b0;
         requests++;
         if (r.req_type == REQ_TICK) begin
            if (move_on) begin
               move_ticks = count_tick(move_ticks);
               if (move_ticks >= ticks_for(move_speed)) begin
                  move_ticks = '0;
                  if (move_left != 0) begin
                     take_step(move_dir);
                     move_left = move_left - 32'd1;
                  end else begin
                     coils   = '0;
                     move_on = 1'b0;
                     moves_done++;
                  end
               end
            end else if (cont_on) begin
               cont_ticks = count_tick(cont_ticks);
               if (cont_ticks >= ticks_for(cont_speed)) begin
                  cont_ticks = '0;
                  take_step(cont_dir);
               end
            end
         end else if (r.req_type <= REQ_ABS && move_on) begin
            refused = 1'b1;
         end else if (r.req_type == REQ_START) begin
            cont_dir   = r.direction;
            cont_speed = r.speed;
            cont_on    = 1'b1;
            cont_ticks = '0;
         end else if (r.req_type == REQ_STOP) begin
            cont_on = 1'b0;
            coils   = '0;
         end else if (r.req_type == REQ_REL) begin
            if (r.step_count == 0) coils = '0;
            else start_move(r.direction, r.step_count, r.speed);
         end else if (r.req_type == REQ_ABS && target != position) begin
            if ($signed(target) > $signed(position))
               start_move(DIR_CW, target - position, r.speed);
            else
               start_move(DIR_CCW, position - target, r.speed);
         end
         res.coils      = coils;
         res.position   = position;
         res.moving     = move_on;
         res.running    = cont_on;
         res.step_taken = (position != start_pos);
         res.rejected   = refused;
         if (res.step_taken) steps++;
         if (refused) rejects++;
         expected_q.push_back(res);
      endfunction

      function void compare_field(string field, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: mismatch on %s: expected %0d, got %0d (t=%0t)",
                        field, exp_v, act_v, $realtime);
         end
      endfunction

      function void check_result(hss_result_type got);
         hss_result_type exp_r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: unexpected response %h (t=%0t)", got, $realtime);
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("coils", exp_r.coils, got.coils);
         compare_field("position", exp_r.position, got.position);
         compare_field("moving", exp_r.moving, got.moving);
         compare_field("running", exp_r.running, got.running);
         compare_field("step_taken", exp_r.step_taken, got.step_taken);
         compare_field("rejected", exp_r.rejected, got.rejected);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   stepper_scoreboard sb = new();

   // Responder: random back-pressure, plus one long hold once requested.
   always @(negedge clock) begin
      if (hold_request && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      hss_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.coils      = rsp_tdata[3:0];
         got.position   = rsp_tdata[35:4];
         got.moving     = rsp_tdata[36];
         got.running    = rsp_tdata[37];
         got.step_taken = rsp_tdata[38];
         got.rejected   = rsp_tdata[39];
         sb.check_result(got);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic hss_request_type make_req(logic [2:0] kind, logic dir,
                                                logic [1:0] spd, logic [31:0] count,
                                                logic [31:0] target);
      hss_request_type r;
      r.req_type        = kind;
      r.direction       = dir;
      r.speed           = spd;
      r.step_count      = count;
      r.target_position = target;
      return r;
   endfunction

   task automatic send_request(input hss_request_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.req_type;
      req_tdata  = {5'b0, r.target_position, r.step_count, r.speed, r.direction};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   // Drop valid, drain every expected response, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input hss_csr_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_interval(idx, value);
   endtask

   task automatic send_directed();
      send_request(make_req(REQ_TICK, DIR_CW, SPEED_NORMAL, 32'd0, 32'd0));
      send_request(make_req(REQ_ABS + 3'd1, DIR_CCW, SPEED_ALT, '1, '1));
      send_request(make_req(REQ_TYPE_MAX, DIR_CW, SPEED_SLOW, 32'd5, 32'd5));
      send_request(make_req(REQ_STOP, DIR_CW, SPEED_NORMAL, 32'd0, 32'd0));
      // zero-length move and a move to where we already are
      send_request(make_req(REQ_REL, DIR_CW, SPEED_FAST, 32'd0, 32'd7));
      send_request(make_req(REQ_ABS, DIR_CCW, SPEED_FAST, 32'd9, 32'd0));
      send_request(make_req(REQ_START, DIR_CW, SPEED_FAST, 32'd0, 32'd0));
      repeat (2) send_request(make_req(REQ_TICK, DIR_CW, SPEED_SLOW, 32'd0, 32'd0));
      // counted move pauses continuous stepping; commands meanwhile are refused
      send_request(make_req(REQ_REL, DIR_CCW, SPEED_ALT, 32'd2, 32'd0));
      send_request(make_req(REQ_START, DIR_CCW, SPEED_SLOW, 32'd0, 32'd0));
      send_request(make_req(REQ_STOP, DIR_CW, SPEED_SLOW, 32'd0, 32'd0));
      send_request(make_req(REQ_REL, DIR_CW, SPEED_FAST, 32'hFFFF_FFFF, 32'd0));
      send_request(make_req(REQ_ABS, DIR_CW, SPEED_FAST, 32'd0, 32'h8000_0000));
      repeat (9) send_request(make_req(REQ_TICK, DIR_CW, SPEED_SLOW, 32'd0, 32'd0));
      send_request(make_req(REQ_ABS, DIR_CW, SPEED_SLOW, 32'd0, -32'sd3));
   endtask

   // Mostly well-formed command sequences with ticks in between.
   function automatic hss_request_type random_req();
      hss_request_type r;
      int unsigned     pick;
      int              delta;
      pick = $urandom_range(99);
      r = make_req(REQ_TICK, 1'($urandom_range(1)), 2'($urandom_range(3)),
                   $urandom, $urandom);
      if (pick < 62) begin
         r.req_type = REQ_TICK;
      end else if (pick < 70) begin
         r.req_type = REQ_START;
      end else if (pick < 75) begin
         r.req_type = REQ_STOP;
      end else if (pick < 85) begin
         r.req_type   = REQ_REL;
         r.step_count = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(6, 1));
      end else if (pick < 95) begin
         delta = int'($urandom_range(16)) - 8;
         r.req_type        = REQ_ABS;
         r.target_position = sb.position + 32'(delta);
      end else begin
         r.req_type = 3'($urandom_range(REQ_TYPE_MAX, REQ_ABS + 3'd1));
      end
      return r;
   endfunction

   initial begin : stimulus
      int unsigned     idle_mix  [4] = '{0, 88, 0, 27};
      int unsigned     stall_mix [4] = '{0, 0, 88, 27};
      logic [7:0]      slow_set  [4] = '{8'd8, 8'd1, 8'd255, 8'd0};
      logic [7:0]      norm_set  [4] = '{8'd4, 8'd2, 8'd3, 8'd0};
      logic [7:0]      fast_set  [4] = '{8'd2, 8'd3, 8'd1, 8'd0};
      hss_request_type r;
      int unsigned     counted;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         if (p == 3) begin
            slow_set[p] = 8'($urandom_range(16, 1));
            norm_set[p] = 8'($urandom_range(16, 1));
            fast_set[p] = 8'($urandom_range(16, 1));
         end
         write_interval(CSR_SLOW, slow_set[p]);
         write_interval(CSR_NORMAL, norm_set[p]);
         write_interval(CSR_FAST, fast_set[p]);
         send_idle_pct = idle_mix[p];
         rsp_stall_pct = stall_mix[p];
         if (p == 0) send_directed();
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            r = random_req();
            if (!(r.req_type == REQ_TICK && !sb.move_on && !sb.cont_on)) counted++;
            send_request(r);
            // hold the responder off while requests keep coming
            if (p == 0 && counted == 150) hold_request = 1'b1;
         end
      end

      // finish on a move too long to complete, with refused commands behind it
      wait_idle();
      if ($urandom_range(1) == 0)
         r = make_req(REQ_REL, 1'($urandom_range(1)), 2'($urandom_range(3)),
                      32'hFFFF_FFFF, '0);
      else
         r = make_req(REQ_ABS, 1'($urandom_range(1)), 2'($urandom_range(3)),
                      '0, 32'h7FFF_FFFF);
      send_request(r);
      repeat (30) send_request(make_req(REQ_TICK, DIR_CW, SPEED_SLOW, $urandom, $urandom));
      send_request(make_req(REQ_STOP, DIR_CCW, SPEED_FAST, $urandom, $urandom));
      send_request(make_req(REQ_START, DIR_CW, SPEED_NORMAL, $urandom, $urandom));

      wait_idle();
      $display("tb_top: %0d requests, %0d half-steps, %0d refused commands, %0d moves ended",
               sb.requests, sb.steps, sb.rejects, sb.moves_done);
      $display("tb_top: four handshake mixes, intervals from 1 to 255, %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
